// ----- design/gffs_pkg.sv -----
package gffs_pkg;

  // Fixed field widths.
  localparam int SYM_W   = 6;
  localparam int SET_W   = 64;
  localparam int OP_W    = 2;
  localparam int CIDX_W  = 2;
  localparam int IN_W    = 16;
  localparam int OUT_W   = 136;
  localparam int UOP_W   = 5;

  // Default sizes.
  localparam int DEF_SYMBOLS     = 64;
  localparam int DEF_PRODUCTIONS = 64;
  localparam int DEF_RHS_SLOTS   = 256;

  // Input opcodes.
  localparam logic [OP_W-1:0] OP_APPEND  = 2'd0;
  localparam logic [OP_W-1:0] OP_COMPUTE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] CFG_TERMINALS = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_EMPTY     = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_START     = 2'd2;
  localparam logic [CIDX_W-1:0] CFG_ENDMARK   = 2'd3;

  // Micro-operations; the controller state codes are these same values.
  localparam logic [UOP_W-1:0] U_IDLE   = 5'd0;
  localparam logic [UOP_W-1:0] U_INIT   = 5'd1;
  localparam logic [UOP_W-1:0] U_FSTART = 5'd2;
  localparam logic [UOP_W-1:0] U_FRHS   = 5'd3;
  localparam logic [UOP_W-1:0] U_FSYM   = 5'd4;
  localparam logic [UOP_W-1:0] U_FACC   = 5'd5;
  localparam logic [UOP_W-1:0] U_FLEFT  = 5'd6;
  localparam logic [UOP_W-1:0] U_FA     = 5'd7;
  localparam logic [UOP_W-1:0] U_FUPD   = 5'd8;
  localparam logic [UOP_W-1:0] U_FLINIT = 5'd9;
  localparam logic [UOP_W-1:0] U_LSTART = 5'd10;
  localparam logic [UOP_W-1:0] U_LSCAN  = 5'd11;
  localparam logic [UOP_W-1:0] U_LCHK   = 5'd12;
  localparam logic [UOP_W-1:0] U_LLEFT  = 5'd13;
  localparam logic [UOP_W-1:0] U_LFA    = 5'd14;
  localparam logic [UOP_W-1:0] U_LTR    = 5'd15;
  localparam logic [UOP_W-1:0] U_LRD    = 5'd16;
  localparam logic [UOP_W-1:0] U_LSYM   = 5'd17;
  localparam logic [UOP_W-1:0] U_LUPD   = 5'd18;
  localparam logic [UOP_W-1:0] U_LNEXT  = 5'd19;
  localparam logic [UOP_W-1:0] U_ERD    = 5'd20;
  localparam logic [UOP_W-1:0] U_ELD    = 5'd21;
  localparam logic [UOP_W-1:0] U_EWAIT  = 5'd22;

  typedef struct packed {
    logic [UOP_W-1:0] uop;
    logic             append;  // load word accepted
    logic             clear;   // clear word accepted
    logic             start;   // compute word accepted
    logic             adv;     // result word taken
  } cmd_t;

  typedef struct packed {
    logic scan_done;   // walk pointer reached the symbol count
    logic end_bit;     // symbol just read closes a production
    logic end_seen;    // registered end flag of the current symbol
    logic seg_first;   // backward walk at the first symbol of the production
    logic changed;     // some set grew during this pass
    logic left_special;
    logic init_last;
    logic emit_last;
  } sts_t;

endpackage

// ----- design/gffs_ctrl.sv -----
module gffs_ctrl
  import gffs_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  input  logic [OP_W-1:0] in_tuser,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  sts_t            sts,
  output cmd_t            cmd
);

  logic [UOP_W-1:0] state_r, state_nxt;
  logic             in_fire;

  assign in_fire    = in_tvalid && (state_r == U_IDLE);
  assign in_tready  = (state_r == U_IDLE);
  assign out_tvalid = (state_r == U_EWAIT);

  // Commands to the datapath.
  always_comb begin
    cmd.uop    = state_r;
    cmd.append = in_fire && (in_tuser == OP_APPEND);
    cmd.clear  = in_fire && (in_tuser == OP_CLEAR);
    cmd.start  = in_fire && (in_tuser == OP_COMPUTE);
    cmd.adv    = (state_r == U_EWAIT) && out_tready;
  end

  // Sequencer for load, initialization, the two fixed-point passes and the result sweep.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      U_IDLE:   if (cmd.start) state_nxt = U_INIT;
      U_INIT:   if (sts.init_last) state_nxt = U_FSTART;
      U_FSTART: state_nxt = U_FRHS;
      U_FRHS: begin
        if (!sts.scan_done) state_nxt = U_FSYM;
        else if (sts.changed) state_nxt = U_FSTART;
        else state_nxt = U_FLINIT;
      end
      U_FSYM:   state_nxt = U_FACC;
      U_FACC:   state_nxt = sts.end_seen ? U_FLEFT : U_FRHS;
      U_FLEFT:  state_nxt = U_FA;
      U_FA:     state_nxt = U_FUPD;
      U_FUPD:   state_nxt = U_FRHS;
      U_FLINIT: state_nxt = U_LSTART;
      U_LSTART: state_nxt = U_LSCAN;
      U_LSCAN: begin
        if (!sts.scan_done) state_nxt = U_LCHK;
        else if (sts.changed) state_nxt = U_LSTART;
        else state_nxt = U_ERD;
      end
      U_LCHK:   state_nxt = sts.end_bit ? U_LLEFT : U_LSCAN;
      U_LLEFT:  state_nxt = U_LFA;
      U_LFA:    state_nxt = U_LTR;
      U_LTR:    state_nxt = sts.left_special ? U_LNEXT : U_LRD;
      U_LRD:    state_nxt = U_LSYM;
      U_LSYM:   state_nxt = U_LUPD;
      U_LUPD:   state_nxt = sts.seg_first ? U_LNEXT : U_LRD;
      U_LNEXT:  state_nxt = U_LSCAN;
      U_ERD:    state_nxt = U_ELD;
      U_ELD:    state_nxt = U_EWAIT;
      U_EWAIT: begin
        if (out_tready) state_nxt = sts.emit_last ? U_IDLE : U_ERD;
      end
      default:  state_nxt = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= U_IDLE;
    else state_r <= state_nxt;
  end

endmodule

// ----- design/gffs_dpath.sv -----
module gffs_dpath
  import gffs_pkg::*;
#(
  parameter int SYMBOLS     = DEF_SYMBOLS,
  parameter int PRODUCTIONS = DEF_PRODUCTIONS,
  parameter int RHS_SLOTS   = DEF_RHS_SLOTS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [SET_W-1:0]  cfg_data,
  input  logic [IN_W-1:0]   in_tdata,
  input  logic              in_tlast,
  output logic [OUT_W-1:0]  out_tdata,
  output logic              out_tlast,
  input  cmd_t              cmd,
  output sts_t              sts
);

  localparam int RC_W = $clog2(RHS_SLOTS + 1);
  localparam int RA_W = (RHS_SLOTS > 1) ? $clog2(RHS_SLOTS) : 1;
  localparam int PC_W = $clog2(PRODUCTIONS + 1);
  localparam int PA_W = (PRODUCTIONS > 1) ? $clog2(PRODUCTIONS) : 1;
  localparam int NSYM = 1 << SYM_W;

  // Configuration registers.
  logic [SET_W-1:0] term_r;
  logic [SYM_W-1:0] empty_r, start_r, endmark_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_r    <= '0;
      empty_r   <= SYM_W'(0);
      start_r   <= SYM_W'(1);
      endmark_r <= SYM_W'(2);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TERMINALS: term_r    <= cfg_data;
        CFG_EMPTY:     empty_r   <= cfg_data[SYM_W-1:0];
        CFG_START:     start_r   <= cfg_data[SYM_W-1:0];
        CFG_ENDMARK:   endmark_r <= cfg_data[SYM_W-1:0];
      endcase
    end
  end

  // Input word fields.
  logic [SYM_W-1:0] in_left, in_sym;
  assign in_left = in_tdata[SYM_W-1:0];
  assign in_sym  = in_tdata[2*SYM_W-1:SYM_W];

  // Walk state.
  logic [RC_W-1:0]  rhs_cnt_r, k_r, j_r, seg_start_r, seg_end_r;
  logic [PC_W-1:0]  prod_cnt_r, p_r;
  logic             ovf_r, changed_r, all_r, endb_r;
  logic [SYM_W-1:0] a_r, s_r, i_r;
  logic [SET_W-1:0] acc_r, trailer_r, null_r;

  // Memory ports.
  logic [SYM_W:0]   rhs_mem [RHS_SLOTS];
  logic [SYM_W-1:0] prod_mem [PRODUCTIONS];
  logic [SET_W-1:0] first_mem [NSYM];
  logic [SET_W-1:0] follow_mem [NSYM];

  logic [RA_W-1:0]  ra;
  logic             rwe;
  logic [SYM_W:0]   rwd, rhs_rd_r;
  logic [PA_W-1:0]  pa;
  logic             pwe;
  logic [SYM_W-1:0] prod_rd_r;
  logic [SYM_W-1:0] fa, la;
  logic             fwe, lwe;
  logic [SET_W-1:0] fwd, lwd, first_rd_r, follow_rd_r;

  function automatic logic special(input logic [SYM_W-1:0] x,
                                   input logic [SYM_W-1:0] e,
                                   input logic [SET_W-1:0] t);
    return (x == e) || t[x];
  endfunction

  logic             load_ok;
  logic [SET_W-1:0] fnew, lnew, init_first;
  logic             fupd, lupd;
  logic [SYM_W-1:0] rd_sym;

  assign rd_sym  = rhs_rd_r[SYM_W-1:0];
  assign load_ok = (rhs_cnt_r < RC_W'(RHS_SLOTS)) &&
                   !(in_tlast && (prod_cnt_r >= PC_W'(PRODUCTIONS)));
  assign init_first = ((i_r != empty_r) && term_r[i_r]) ? (SET_W'(1) << i_r) : '0;
  assign fnew = first_rd_r | acc_r;
  assign fupd = !special(a_r, empty_r, term_r) &&
                ((fnew != first_rd_r) || (all_r && !null_r[a_r]));
  assign lnew = follow_rd_r | trailer_r;
  assign lupd = !special(s_r, empty_r, term_r) && (lnew != follow_rd_r);

  // Memory address and write selection per micro-operation.
  always_comb begin
    ra  = k_r[RA_W-1:0];
    rwe = 1'b0;
    rwd = {in_tlast, in_sym};
    pa  = p_r[PA_W-1:0];
    pwe = 1'b0;
    fa  = i_r;
    fwe = 1'b0;
    fwd = fnew;
    la  = i_r;
    lwe = 1'b0;
    lwd = lnew;
    case (cmd.uop)
      U_IDLE: begin
        ra = rhs_cnt_r[RA_W-1:0];
        pa = prod_cnt_r[PA_W-1:0];
        if (cmd.append && load_ok) begin
          rwe = 1'b1;
          pwe = in_tlast;
        end
      end
      U_INIT: begin
        fwe = 1'b1;
        fwd = init_first;
        lwe = 1'b1;
        lwd = '0;
      end
      U_FSYM:   fa = rd_sym;
      U_FA:     fa = prod_rd_r;
      U_FUPD: begin
        fa  = a_r;
        fwe = fupd;
      end
      U_FLINIT: begin
        la  = start_r;
        lwe = 1'b1;
        lwd = SET_W'(1) << endmark_r;
      end
      U_LFA:    la = prod_rd_r;
      U_LRD:    ra = j_r[RA_W-1:0];
      U_LSYM: begin
        fa = rd_sym;
        la = rd_sym;
      end
      U_LUPD: begin
        la  = s_r;
        lwe = lupd;
      end
      default: ;
    endcase
  end

  // Memories with registered read data.
  always_ff @(posedge clk) begin
    if (rwe) rhs_mem[ra] <= rwd;
    rhs_rd_r <= rhs_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (pwe) prod_mem[pa] <= in_left;
    prod_rd_r <= prod_mem[pa];
  end

  always_ff @(posedge clk) begin
    if (fwe) first_mem[fa] <= fwd;
    first_rd_r <= first_mem[fa];
  end

  always_ff @(posedge clk) begin
    if (lwe) follow_mem[la] <= lwd;
    follow_rd_r <= follow_mem[la];
  end

  // Store counters and the overflow flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rhs_cnt_r  <= '0;
      prod_cnt_r <= '0;
      ovf_r      <= 1'b0;
    end else if (cmd.clear) begin
      rhs_cnt_r  <= '0;
      prod_cnt_r <= '0;
      ovf_r      <= 1'b0;
    end else if (cmd.append) begin
      if (!load_ok) begin
        ovf_r <= 1'b1;
      end else begin
        rhs_cnt_r <= rhs_cnt_r + RC_W'(1);
        if (in_tlast) prod_cnt_r <= prod_cnt_r + PC_W'(1);
      end
    end
  end

  // Walk registers for initialization, both passes and the result sweep.
  always_ff @(posedge clk) begin
    case (cmd.uop)
      U_IDLE: if (cmd.start) i_r <= '0;
      U_INIT: begin
        i_r <= i_r + SYM_W'(1);
        if (i_r == SYM_W'(NSYM - 1)) null_r <= SET_W'(1) << empty_r;
      end
      U_FSTART, U_LSTART: begin
        k_r         <= '0;
        p_r         <= '0;
        seg_start_r <= '0;
        changed_r   <= 1'b0;
        acc_r       <= '0;
        all_r       <= 1'b1;
      end
      U_FSYM: begin
        s_r    <= rd_sym;
        endb_r <= rhs_rd_r[SYM_W];
      end
      U_FACC: begin
        if (all_r) begin
          acc_r <= acc_r | first_rd_r;
          if (!null_r[s_r]) all_r <= 1'b0;
        end
        if (!endb_r) k_r <= k_r + RC_W'(1);
      end
      U_FA: a_r <= prod_rd_r;
      U_FUPD: begin
        if (fupd) begin
          changed_r <= 1'b1;
          if (all_r) null_r[a_r] <= 1'b1;
        end
        p_r   <= p_r + PC_W'(1);
        k_r   <= k_r + RC_W'(1);
        acc_r <= '0;
        all_r <= 1'b1;
      end
      U_LCHK: begin
        if (rhs_rd_r[SYM_W]) seg_end_r <= k_r;
        else k_r <= k_r + RC_W'(1);
      end
      U_LFA: a_r <= prod_rd_r;
      U_LTR: begin
        trailer_r <= follow_rd_r;
        j_r       <= seg_end_r;
      end
      U_LSYM: s_r <= rd_sym;
      U_LUPD: begin
        if (lupd) changed_r <= 1'b1;
        trailer_r <= null_r[s_r] ? (trailer_r | first_rd_r) : first_rd_r;
        if (j_r != seg_start_r) j_r <= j_r - RC_W'(1);
      end
      U_LNEXT: begin
        p_r         <= p_r + PC_W'(1);
        k_r         <= seg_end_r + RC_W'(1);
        seg_start_r <= seg_end_r + RC_W'(1);
      end
      U_EWAIT: if (cmd.adv) i_r <= i_r + SYM_W'(1);
      default: ;
    endcase
  end

  // Result word register.
  always_ff @(posedge clk) begin
    if (cmd.uop == U_ELD) begin
      out_tdata <= {ovf_r,
                    special(i_r, empty_r, term_r) ? SET_W'(0) : follow_rd_r,
                    null_r[i_r],
                    first_rd_r,
                    i_r};
      out_tlast <= (i_r == SYM_W'(SYMBOLS - 1));
    end
  end

  // Status to the controller.
  always_comb begin
    sts.scan_done    = (k_r >= rhs_cnt_r);
    sts.end_bit      = rhs_rd_r[SYM_W];
    sts.end_seen     = endb_r;
    sts.seg_first    = (j_r == seg_start_r);
    sts.changed      = changed_r;
    sts.left_special = special(a_r, empty_r, term_r);
    sts.init_last    = (i_r == SYM_W'(NSYM - 1));
    sts.emit_last    = (i_r == SYM_W'(SYMBOLS - 1));
  end

endmodule

// ----- design/grammar_first_follow_sets.sv -----
// Load and clear words are accepted back to back.
// A compute word stalls input through set initialization, FIRST passes and
// FOLLOW passes, each pass repeated until no set grows, and then through the
// result sweep until the last result word is taken.
// Reset (rst_n low, synchronous) empties the stores and restores the configuration registers.
module grammar_first_follow_sets
  import gffs_pkg::*;
#(
  parameter int SYMBOLS     = DEF_SYMBOLS,
  parameter int PRODUCTIONS = DEF_PRODUCTIONS,
  parameter int RHS_SLOTS   = DEF_RHS_SLOTS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [SET_W-1:0]  cfg_data,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,   // left_symbol, rhs_symbol, zero pad
  input  logic [OP_W-1:0]   in_tuser,   // opcode
  input  logic              in_tlast,   // rhs_end
  output logic              out_tvalid,
  input  logic              out_tready,
  // symbol_index, first_bits, is_nullable, follow_bits, store_overflow
  output logic [OUT_W-1:0]  out_tdata,
  output logic              out_tlast   // last_result
);

  cmd_t cmd;
  sts_t sts;

  gffs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tuser   (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  gffs_dpath #(
    .SYMBOLS     (SYMBOLS),
    .PRODUCTIONS (PRODUCTIONS),
    .RHS_SLOTS   (RHS_SLOTS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
